// File: rtl/assert_macros.svh
// Assertion macros shared by the tile CRC change detector RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define TCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold at the sampled edge after the antecedent.
`define TCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tcd_pkg.sv
// Shared types, constants and CRC-32 helper functions for the tile CRC change detector.
// No dependencies.
`timescale 1ns / 1ps

package tcd_pkg;

    localparam int PIX_W   = 32;
    localparam int HASH_W  = 32;
    localparam int TIDX_W  = 12;
    localparam int FDIM_W  = 14;
    localparam int TDIM_W  = 11;
    localparam int TPR_W   = 15;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int DEF_MAX_TILE_COLS = 64;
    localparam int DEF_MAX_TILES     = 4096;

    localparam int FW_RESET_VAL = 1920;
    localparam int FH_RESET_VAL = 1080;
    localparam int TW_RESET_VAL = 64;
    localparam int TH_RESET_VAL = 64;
    localparam int TPR_RESET_VAL = (FW_RESET_VAL + TW_RESET_VAL - 1) / TW_RESET_VAL;

    localparam logic [HASH_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [HASH_W-1:0] CRC_INIT = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_TILE_WIDTH   = 3'd2,
        REG_TILE_HEIGHT  = 3'd3,
        REG_FAST_MODE    = 3'd4
    } tcd_reg_t;

    typedef struct packed {
        logic in_range;
        logic first;
        logic hash;
        logic fast;
        logic emit;
        logic end_frame;
    } tcd_flags_t;

    typedef struct packed {
        logic [TIDX_W-1:0] tile_index;
        logic [HASH_W-1:0] tile_hash;
        logic              changed;
        logic              last_of_frame;
    } tcd_result_t;

    function automatic int addr_w(int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Column j of slicing table k: bit j pushed through 8*(k+1) CRC shifts.
    function automatic logic [HASH_W-1:0] crc_col(int k, int j);
        logic [HASH_W-1:0] c;
        c = HASH_W'(1) << j;
        for (int s = 0; s < 8 * (k + 1); s++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Slicing table k, built as the xor of the columns picked by the byte.
    function automatic logic [HASH_W-1:0] crc_tab(int k, logic [7:0] b);
        logic [HASH_W-1:0] r;
        r = '0;
        for (int j = 0; j < 8; j++) begin
            if (b[j]) begin
                r = r ^ crc_col(k, j);
            end
        end
        return r;
    endfunction

    // Four bytes, low byte first.
    function automatic logic [HASH_W-1:0] crc_upd4(logic [HASH_W-1:0] crc,
                                                   logic [PIX_W-1:0] px);
        logic [HASH_W-1:0] x;
        x = crc ^ px;
        return crc_tab(3, x[7:0]) ^ crc_tab(2, x[15:8]) ^
               crc_tab(1, x[23:16]) ^ crc_tab(0, x[31:24]);
    endfunction

    // Three low bytes (B, G, R), low byte first.
    function automatic logic [HASH_W-1:0] crc_upd3(logic [HASH_W-1:0] crc,
                                                   logic [PIX_W-1:0] px);
        logic [23:0] x;
        x = crc[23:0] ^ px[23:0];
        return {24'd0, crc[31:24]} ^ crc_tab(2, x[7:0]) ^
               crc_tab(1, x[15:8]) ^ crc_tab(0, x[23:16]);
    endfunction

endpackage

// File: rtl/tcd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on tcd_pkg for the address width helper.
`timescale 1ns / 1ps

module tcd_ram import tcd_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = addr_w(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tcd_div.sv
// Restoring divider for tiles per row = ceil(frame_width / tile_width), one bit per cycle.
// Depends on tcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcd_div import tcd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FDIM_W-1:0] frame_width,
    input  logic [TDIM_W-1:0] tile_width,
    output logic              busy,
    output logic [TPR_W-1:0]  tiles_per_row
);

    localparam int ITER  = TPR_W;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [TDIM_W-1:0] rem_reg, rem_next;
    logic [TPR_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    logic [FDIM_W-1:0] fw1;
    logic [TDIM_W-1:0] tw1;
    logic [TPR_W-1:0]  numer;
    logic [TDIM_W:0]   rem_sh;
    logic [TDIM_W:0]   rem_sub;
    logic              q_bit;

    always_comb
    begin
        fw1     = (frame_width == '0) ? FDIM_W'(1) : frame_width;
        tw1     = (tile_width == '0) ? TDIM_W'(1) : tile_width;
        numer   = TPR_W'(fw1) + TPR_W'(tw1) - TPR_W'(1);
        rem_sh  = {rem_reg, quo_reg[TPR_W-1]};
        rem_sub = rem_sh - {1'b0, tw1};
        q_bit   = (rem_sh >= {1'b0, tw1});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = numer;
            cnt_next  = CNT_W'(ITER);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = q_bit ? rem_sub[TDIM_W-1:0] : rem_sh[TDIM_W-1:0];
            quo_next  = {quo_reg[TPR_W-2:0], q_bit};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= TPR_W'(TPR_RESET_VAL);
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy          = busy_reg;
    assign tiles_per_row = quo_reg;

    `TCD_ASSERT(a_div_length, $fell(busy_reg) |-> $past(start, ITER + 1), "divider finished early or late")

endmodule

// File: rtl/tcd_pos.sv
// Raster position tracker: pixel and tile coordinates, tile column and row base.
// Produces the memory addresses and control flags for each accepted pixel. Depends on tcd_pkg.
`timescale 1ns / 1ps

module tcd_pos import tcd_pkg::*; #(
    parameter int MAX_TILE_COLS = DEF_MAX_TILE_COLS,
    parameter int MAX_TILES     = DEF_MAX_TILES,
    localparam int CA_W = addr_w(MAX_TILE_COLS),
    localparam int HA_W = addr_w(MAX_TILES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              frame_start,
    input  logic [FDIM_W-1:0] frame_width,
    input  logic [FDIM_W-1:0] frame_height,
    input  logic [TDIM_W-1:0] tile_width,
    input  logic [TDIM_W-1:0] tile_height,
    input  logic              fast_mode,
    input  logic [TPR_W-1:0]  tiles_per_row,
    output tcd_flags_t        flags,
    output logic [CA_W-1:0]   col_addr,
    output logic [HA_W-1:0]   hash_addr,
    output logic [TIDX_W-1:0] tile_index
);

    localparam int TC_W  = $clog2(MAX_TILE_COLS + 1);
    localparam int TRB_W = $clog2(MAX_TILES + 1);
    localparam int IDX_W = $clog2(MAX_TILES + MAX_TILE_COLS + 1);
    localparam int SUM_W = ((TRB_W > TPR_W) ? TRB_W : TPR_W) + 1;
    localparam int FX_W  = FDIM_W + 1;
    localparam int TX_W  = TDIM_W + 1;

    logic [FDIM_W-1:0] pos_x_reg, pos_x_next;
    logic [FDIM_W-1:0] pos_y_reg, pos_y_next;
    logic [TDIM_W-1:0] xt_reg, xt_next;
    logic [TDIM_W-1:0] yt_reg, yt_next;
    logic [TC_W-1:0]   tc_reg, tc_next;
    logic [TRB_W-1:0]  trb_reg, trb_next;

    logic [FDIM_W-1:0] cur_x, cur_y, fw1, fh1;
    logic [TDIM_W-1:0] cur_xt, cur_yt, tw1, th1;
    logic [TC_W-1:0]   cur_tc;
    logic [TRB_W-1:0]  cur_trb;
    logic [IDX_W-1:0]  idx;
    logic [SUM_W-1:0]  trb_sum;
    logic              end_line, last_row, end_frame, last_x, last_y;

    always_comb
    begin
        // frame_start restarts the position before this pixel is placed
        cur_x   = frame_start ? '0 : pos_x_reg;
        cur_y   = frame_start ? '0 : pos_y_reg;
        cur_xt  = frame_start ? '0 : xt_reg;
        cur_yt  = frame_start ? '0 : yt_reg;
        cur_tc  = frame_start ? '0 : tc_reg;
        cur_trb = frame_start ? '0 : trb_reg;

        fw1 = (frame_width  == '0) ? FDIM_W'(1) : frame_width;
        fh1 = (frame_height == '0) ? FDIM_W'(1) : frame_height;
        tw1 = (tile_width   == '0) ? TDIM_W'(1) : tile_width;
        th1 = (tile_height  == '0) ? TDIM_W'(1) : tile_height;

        end_line  = (FX_W'(cur_x) + FX_W'(1)) >= FX_W'(fw1);
        last_row  = (FX_W'(cur_y) + FX_W'(1)) >= FX_W'(fh1);
        end_frame = end_line && last_row;
        last_x    = ((TX_W'(cur_xt) + TX_W'(1)) >= TX_W'(tw1)) || end_line;
        last_y    = ((TX_W'(cur_yt) + TX_W'(1)) >= TX_W'(th1)) || last_row;

        idx     = IDX_W'(cur_trb) + IDX_W'(cur_tc);
        trb_sum = SUM_W'(cur_trb) + SUM_W'(tiles_per_row);
    end

    always_comb
    begin
        flags.in_range  = (cur_tc < TC_W'(MAX_TILE_COLS)) && (idx < IDX_W'(MAX_TILES));
        flags.first     = (cur_xt == '0) && (cur_yt == '0);
        flags.hash      = !fast_mode || (!cur_xt[0] && !cur_yt[0]);
        flags.fast      = fast_mode;
        flags.emit      = last_x && last_y;
        flags.end_frame = end_frame;
        col_addr        = CA_W'(cur_tc);
        hash_addr       = HA_W'(idx);
        tile_index      = TIDX_W'(idx);
    end

    always_comb
    begin
        pos_x_next = cur_x;
        pos_y_next = cur_y;
        xt_next    = cur_xt;
        yt_next    = cur_yt;
        tc_next    = cur_tc;
        trb_next   = cur_trb;
        if (end_frame)
        begin
            pos_x_next = '0;
            pos_y_next = '0;
            xt_next    = '0;
            yt_next    = '0;
            tc_next    = '0;
            trb_next   = '0;
        end
        else if (end_line)
        begin
            pos_x_next = '0;
            xt_next    = '0;
            tc_next    = '0;
            pos_y_next = cur_y + FDIM_W'(1);
            if (last_y)
            begin
                yt_next  = '0;
                trb_next = (trb_sum > SUM_W'(MAX_TILES)) ? TRB_W'(MAX_TILES)
                                                         : TRB_W'(trb_sum);
            end
            else
            begin
                yt_next = cur_yt + TDIM_W'(1);
            end
        end
        else
        begin
            pos_x_next = cur_x + FDIM_W'(1);
            if (last_x)
            begin
                xt_next = '0;
                // saturate at the column limit
                if (cur_tc < TC_W'(MAX_TILE_COLS))
                begin
                    tc_next = cur_tc + TC_W'(1);
                end
            end
            else
            begin
                xt_next = cur_xt + TDIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            xt_reg    <= '0;
            yt_reg    <= '0;
            tc_reg    <= '0;
            trb_reg   <= '0;
        end
        else if (accept)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            xt_reg    <= xt_next;
            yt_reg    <= yt_next;
            tc_reg    <= tc_next;
            trb_reg   <= trb_next;
        end
    end

endmodule

// File: rtl/tcd_outq.sv
// Two-entry result queue between the hash stage and the output channel.
// Depends on tcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcd_outq import tcd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tcd_result_t push_data,
    input  logic        out_stall,
    output logic        out_valid,
    output tcd_result_t out_data,
    output logic        room
);

    tcd_result_t entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    always_comb
    begin
        pop       = (cnt_reg != 2'd0) && !out_stall;
        out_valid = (cnt_reg != 2'd0);
        out_data  = entry_reg[rd_ptr_reg];
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        // a new transaction may follow only if one slot stays free for it
        room      = (cnt_next <= 2'd1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    `TCD_ASSERT(a_no_overflow, !(push && (cnt_reg == 2'd2) && !pop), "result queue overflow")

endmodule

// File: rtl/tile_crc_change_detector_core.sv
// Tile CRC change detector: per-tile CRC-32 of a pixel stream, compared with the previous frame.
// A result passes through the stage 1 registers and the result queue before it is offered.
// Throughput: one pixel per cycle while in_stall is low; the column CRC and stored hash RAMs are read, updated and
// written back in a two-stage pipeline with write-back forwarding.
// After a write to frame_width or tile_width the input stalls for the tiles-per-row divide.
// After reset the input stalls while all MAX_TILES (4096 by default) hash RAM entries are cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tile_crc_change_detector_core import tcd_pkg::*; #(
    parameter int MAX_TILE_COLS = DEF_MAX_TILE_COLS,
    parameter int MAX_TILES     = DEF_MAX_TILES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIX_W-1:0]   pixel,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [TIDX_W-1:0]  tile_index,
    output logic [HASH_W-1:0]  tile_hash,
    output logic               changed,
    output logic               last_of_frame
);

    localparam int CA_W = addr_w(MAX_TILE_COLS);
    localparam int HA_W = addr_w(MAX_TILES);

    // configuration
    logic [FDIM_W-1:0] fw_reg, fh_reg;
    logic [TDIM_W-1:0] tw_reg, th_reg;
    logic              fast_reg;
    logic              cfg_we;
    logic [2:0]        reg_idx;
    logic              div_start_reg;
    logic              div_busy;
    logic [TPR_W-1:0]  tiles_per_row;

    // hash RAM clear after reset
    logic              clr_active_reg;
    logic [HA_W-1:0]   clr_addr_reg;

    // stage 0 outputs
    logic              in_acc;
    tcd_flags_t        s0_flags;
    logic [CA_W-1:0]   s0_col;
    logic [HA_W-1:0]   s0_haddr;
    logic [TIDX_W-1:0] s0_tidx;

    // stage 1
    logic              s1_valid_reg;
    tcd_flags_t        s1_flags_reg;
    logic [CA_W-1:0]   s1_col_reg;
    logic [HA_W-1:0]   s1_haddr_reg;
    logic [TIDX_W-1:0] s1_tidx_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;

    logic [HASH_W-1:0] col_rdata, hash_rdata;
    logic [HASH_W-1:0] crc_base, crc_new, hash_new, hash_prev;
    logic              col_we, hash_item_we;
    logic              hash_we;
    logic [HA_W-1:0]   hash_waddr;
    logic [HASH_W-1:0] hash_wdata;

    // last write to each RAM, covers a read issued on the same edge
    logic              cwb_valid_reg, hwb_valid_reg;
    logic [CA_W-1:0]   cwb_addr_reg;
    logic [HA_W-1:0]   hwb_addr_reg;
    logic [HASH_W-1:0] cwb_data_reg, hwb_data_reg;

    tcd_result_t       res_push, res_out;
    logic              q_room;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(fw_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(fh_reg);
            REG_TILE_WIDTH:   prdata = PDATA_W'(tw_reg);
            REG_TILE_HEIGHT:  prdata = PDATA_W'(th_reg);
            REG_FAST_MODE:    prdata = PDATA_W'(fast_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= FDIM_W'(FW_RESET_VAL);
            fh_reg        <= FDIM_W'(FH_RESET_VAL);
            tw_reg        <= TDIM_W'(TW_RESET_VAL);
            th_reg        <= TDIM_W'(TH_RESET_VAL);
            fast_reg      <= 1'b1;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= cfg_we &&
                             (reg_idx == REG_FRAME_WIDTH || reg_idx == REG_TILE_WIDTH);
            if (cfg_we)
            begin
                case (reg_idx)
                    REG_FRAME_WIDTH:  fw_reg   <= pwdata[FDIM_W-1:0];
                    REG_FRAME_HEIGHT: fh_reg   <= pwdata[FDIM_W-1:0];
                    REG_TILE_WIDTH:   tw_reg   <= pwdata[TDIM_W-1:0];
                    REG_TILE_HEIGHT:  th_reg   <= pwdata[TDIM_W-1:0];
                    REG_FAST_MODE:    fast_reg <= pwdata[0];
                    default:          fast_reg <= fast_reg;
                endcase
            end
        end
    end

    tcd_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (div_start_reg),
        .frame_width   (fw_reg),
        .tile_width    (tw_reg),
        .busy          (div_busy),
        .tiles_per_row (tiles_per_row)
    );

    // ---------------- clear pass ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + HA_W'(1);
            if (clr_addr_reg == HA_W'(MAX_TILES - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ---------------- stage 0: position and RAM reads ----------------
    assign in_stall = clr_active_reg || div_start_reg || div_busy || !q_room;
    assign in_acc   = in_valid && !in_stall;

    tcd_pos #(
        .MAX_TILE_COLS (MAX_TILE_COLS),
        .MAX_TILES     (MAX_TILES)
    ) u_pos (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_acc),
        .frame_start   (frame_start),
        .frame_width   (fw_reg),
        .frame_height  (fh_reg),
        .tile_width    (tw_reg),
        .tile_height   (th_reg),
        .fast_mode     (fast_reg),
        .tiles_per_row (tiles_per_row),
        .flags         (s0_flags),
        .col_addr      (s0_col),
        .hash_addr     (s0_haddr),
        .tile_index    (s0_tidx)
    );

    tcd_ram #(
        .WIDTH (HASH_W),
        .DEPTH (MAX_TILE_COLS)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (s1_col_reg),
        .wdata (crc_new),
        .raddr (s0_col),
        .rdata (col_rdata)
    );

    tcd_ram #(
        .WIDTH (HASH_W),
        .DEPTH (MAX_TILES)
    ) u_hash_ram (
        .clk   (clk),
        .we    (hash_we),
        .waddr (hash_waddr),
        .wdata (hash_wdata),
        .raddr (s0_haddr),
        .rdata (hash_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_flags_reg <= s0_flags;
            s1_col_reg   <= s0_col;
            s1_haddr_reg <= s0_haddr;
            s1_tidx_reg  <= s0_tidx;
            s1_pixel_reg <= pixel;
        end
    end

    // ---------------- stage 1: CRC update, compare, write back ----------------
    always_comb
    begin
        if (s1_flags_reg.first)
        begin
            crc_base = CRC_INIT;
        end
        else if (cwb_valid_reg && (cwb_addr_reg == s1_col_reg))
        begin
            crc_base = cwb_data_reg;
        end
        else
        begin
            crc_base = col_rdata;
        end

        if (!s1_flags_reg.hash)
        begin
            crc_new = crc_base;
        end
        else if (s1_flags_reg.fast)
        begin
            crc_new = crc_upd3(crc_base, s1_pixel_reg);
        end
        else
        begin
            crc_new = crc_upd4(crc_base, s1_pixel_reg);
        end

        hash_new  = crc_new ^ CRC_INIT;
        hash_prev = (hwb_valid_reg && (hwb_addr_reg == s1_haddr_reg)) ? hwb_data_reg
                                                                       : hash_rdata;

        col_we       = s1_valid_reg && s1_flags_reg.in_range;
        hash_item_we = col_we && s1_flags_reg.emit;

        hash_we    = clr_active_reg || hash_item_we;
        hash_waddr = clr_active_reg ? clr_addr_reg : s1_haddr_reg;
        hash_wdata = clr_active_reg ? '0 : hash_new;

        res_push.tile_index    = s1_tidx_reg;
        res_push.tile_hash     = hash_new;
        res_push.changed       = (hash_new != hash_prev);
        res_push.last_of_frame = s1_flags_reg.end_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cwb_valid_reg <= 1'b0;
            hwb_valid_reg <= 1'b0;
        end
        else
        begin
            if (col_we)
            begin
                cwb_valid_reg <= 1'b1;
            end
            if (hash_item_we)
            begin
                hwb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            cwb_addr_reg <= s1_col_reg;
            cwb_data_reg <= crc_new;
        end
        if (hash_item_we)
        begin
            hwb_addr_reg <= s1_haddr_reg;
            hwb_data_reg <= hash_new;
        end
    end

    // ---------------- output ----------------
    tcd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (hash_item_we),
        .push_data (res_push),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (res_out),
        .room      (q_room)
    );

    assign tile_index    = res_out.tile_index;
    assign tile_hash     = res_out.tile_hash;
    assign changed       = res_out.changed;
    assign last_of_frame = res_out.last_of_frame;

    `TCD_ASSERT(a_clr_no_accept, !(clr_active_reg && in_acc), "transaction accepted during hash clear")
    `TCD_ASSERT(a_clr_no_item_write, !(clr_active_reg && hash_item_we), "hash write collides with clear")
    `TCD_ASSERT_NEXT(a_div_holds_input, div_start_reg, in_stall, "input not held during divide")

endmodule
